// ===== rtl/rls_pkg.sv =====
// Shared types and constants for the reversible LIFO stack unit.
`default_nettype none

package rls_pkg;

	localparam int DATA_W      = 32;
	localparam int OP_W        = 3;
	localparam int COUNT_OUT_W = 7;
	localparam int STATUS_W    = 2;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH   = 3'd0,
		OP_POP    = 3'd1,
		OP_POPN   = 3'd2,
		OP_REMOVE = 3'd3,
		OP_REV    = 3'd4,
		OP_CHECK  = 3'd5
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_READ,
		S_FINISH
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/rls_if.sv =====
// Operation and result channels of the reversible LIFO stack unit.
`default_nettype none

interface rls_op_if;
	logic                               valid;
	logic                               ready;
	logic [rls_pkg::OP_W-1:0]           op;
	logic signed [rls_pkg::DATA_W-1:0]  value;

	modport source (output valid, output op, output value, input ready);
	modport sink   (input valid, input op, input value, output ready);
endinterface

interface rls_res_if;
	logic                                valid;
	logic                                ready;
	logic signed [rls_pkg::DATA_W-1:0]   top_value;
	logic signed [rls_pkg::DATA_W-1:0]   bottom_value;
	logic [rls_pkg::COUNT_OUT_W-1:0]     entry_count;
	logic                                is_empty;
	logic                                is_ordered;
	logic [rls_pkg::STATUS_W-1:0]        status;

	modport source (output valid, output top_value, output bottom_value, output entry_count,
		output is_empty, output is_ordered, output status, input ready);
	modport sink   (input valid, input top_value, input bottom_value, input entry_count,
		input is_empty, input is_ordered, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/rls_ram.sv =====
// Entry memory: one write port and two registered read ports.
`default_nettype none

module rls_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire logic                          clk,
	input  wire logic                          we,
	input  wire logic [AW-1:0]                 waddr,
	input  wire logic [rls_pkg::DATA_W-1:0]    wdata,
	input  wire logic [AW-1:0]                 raddr_a,
	input  wire logic [AW-1:0]                 raddr_b,
	output logic      [rls_pkg::DATA_W-1:0]    rdata_a,
	output logic      [rls_pkg::DATA_W-1:0]    rdata_b
);

	logic [rls_pkg::DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

`default_nettype wire

// ===== rtl/reversible_lifo_stack_unit.sv =====
// Top level of the reversible LIFO stack unit.
// Bounded stack of signed 32-bit words kept in a ring memory; reverse only flips a direction
// bit, so push, pop, pop-several, remove-bottom and reverse all pass from accept to result
// through the same steps (accept and pointer update with the write, then a top/bottom read,
// then the result register). An order check of two or more entries adds a scan before the read,
// in which the two memory read ports compare one adjacent pair of entries per cycle. One
// operation is in flight at a time; a new operation is accepted while the previous result
// waits in the output register. The memory needs no clearing after reset.
`default_nettype none

module reversible_lifo_stack_unit #(
	parameter int STACK_DEPTH = 64
) (
	input wire logic   clk,
	input wire logic   arst_n,
	rls_op_if.sink     req,
	rls_res_if.source  rsp
);

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int SW = AW + 1;

	rls_pkg::state_t  state_q, state_d;
	rls_pkg::status_t status_q, status_d;
	rls_pkg::op_t     op_q;

	logic [AW-1:0] base_q, base_d;
	logic [CW-1:0] count_q, count_d;
	logic          rev_q, rev_d;
	logic [CW-1:0] scan_idx_q;
	logic          ord_q;
	logic          cmp_vld_s1;
	logic          rsp_valid_q;

	logic                       we;
	logic [AW-1:0]              waddr;
	logic [AW-1:0]              raddr_a, raddr_b;
	logic [rls_pkg::DATA_W-1:0] rdata_a, rdata_b;

	logic                       accept;
	logic                       load_out;
	logic                       empty, full;
	logic [AW-1:0]              base_inc, base_dec;
	logic [CW-1:0]              pop_n;

	logic signed [rls_pkg::DATA_W-1:0] top_q, bottom_q;
	logic [rls_pkg::COUNT_OUT_W-1:0]   cnt_out_q;
	logic                              empty_out_q, ord_out_q;
	rls_pkg::status_t                  status_out_q;

	function automatic logic [AW-1:0] wrap(input logic [SW-1:0] s);
		return (s >= SW'(STACK_DEPTH)) ? AW'(s - SW'(STACK_DEPTH)) : AW'(s);
	endfunction

	// ring slot of position pos counted from the bottom
	function automatic logic [AW-1:0] slot_of(input logic [CW-1:0] pos);
		logic [CW-1:0] off;
		off = rev_q ? (count_q - CW'(1) - pos) : pos;
		return wrap(SW'(base_q) + SW'(off));
	endfunction

	assign req.ready = (state_q == rls_pkg::S_IDLE);
	assign accept    = req.valid && req.ready;

	assign empty    = (count_q == '0);
	assign full     = (count_q == CW'(STACK_DEPTH));
	assign base_inc = (base_q == AW'(STACK_DEPTH - 1)) ? '0 : base_q + AW'(1);
	assign base_dec = (base_q == '0) ? AW'(STACK_DEPTH - 1) : base_q - AW'(1);

	// clamp the pop-several count to 0..count
	always_comb begin
		if (req.value[rls_pkg::DATA_W-1]) begin
			pop_n = '0;
		end else if (req.value > $signed({{(rls_pkg::DATA_W - CW){1'b0}}, count_q})) begin
			pop_n = count_q;
		end else begin
			pop_n = req.value[CW-1:0];
		end
	end

	// pointer update and memory write for the accepted word
	always_comb begin
		base_d   = base_q;
		count_d  = count_q;
		rev_d    = rev_q;
		status_d = rls_pkg::ST_OK;
		we       = 1'b0;
		waddr    = wrap(SW'(base_q) + SW'(count_q));
		case (rls_pkg::op_t'(req.op))
			rls_pkg::OP_PUSH: begin
				if (full) begin
					status_d = rls_pkg::ST_FULL;
				end else begin
					we      = accept;
					count_d = count_q + CW'(1);
					if (rev_q) begin
						base_d = base_dec;
						waddr  = base_dec;
					end
				end
			end
			rls_pkg::OP_POP: begin
				if (empty) begin
					status_d = rls_pkg::ST_EMPTY;
				end else begin
					count_d = count_q - CW'(1);
					if (rev_q) begin
						base_d = base_inc;
					end
				end
			end
			rls_pkg::OP_POPN: begin
				count_d = count_q - pop_n;
				if (rev_q) begin
					base_d = wrap(SW'(base_q) + SW'(pop_n));
				end
				if (empty && !req.value[rls_pkg::DATA_W-1] && (req.value != '0)) begin
					status_d = rls_pkg::ST_EMPTY;
				end
			end
			rls_pkg::OP_REMOVE: begin
				if (empty) begin
					status_d = rls_pkg::ST_EMPTY;
				end else begin
					count_d = count_q - CW'(1);
					if (!rev_q) begin
						base_d = base_inc;
					end
				end
			end
			rls_pkg::OP_REV: begin
				rev_d = !rev_q;
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rls_pkg::S_IDLE: begin
				if (accept) begin
					if ((rls_pkg::op_t'(req.op) == rls_pkg::OP_CHECK) && (count_q > CW'(1))) begin
						state_d = rls_pkg::S_SCAN;
					end else begin
						state_d = rls_pkg::S_READ;
					end
				end
			end
			rls_pkg::S_SCAN: begin
				if (scan_idx_q == count_q - CW'(1)) begin
					state_d = rls_pkg::S_READ;
				end
			end
			rls_pkg::S_READ: begin
				state_d = rls_pkg::S_FINISH;
			end
			rls_pkg::S_FINISH: begin
				if (load_out) begin
					state_d = rls_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = rls_pkg::S_IDLE;
			end
		endcase
	end

	// read addresses and result load
	always_comb begin
		raddr_a  = slot_of(count_q - CW'(1));
		raddr_b  = slot_of('0);
		load_out = 1'b0;
		case (state_q)
			rls_pkg::S_SCAN: begin
				raddr_a = slot_of(scan_idx_q);
				raddr_b = slot_of(scan_idx_q - CW'(1));
			end
			rls_pkg::S_FINISH: begin
				load_out = !rsp_valid_q || rsp.ready;
			end
			default: begin
			end
		endcase
	end

	rls_ram #(
		.DEPTH (STACK_DEPTH),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (req.value),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rls_pkg::S_IDLE;
			base_q      <= '0;
			count_q     <= '0;
			rev_q       <= 1'b0;
			status_q    <= rls_pkg::ST_OK;
			op_q        <= rls_pkg::OP_PUSH;
			scan_idx_q  <= '0;
			ord_q       <= 1'b1;
			cmp_vld_s1  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			cmp_vld_s1 <= (state_q == rls_pkg::S_SCAN);
			if (accept) begin
				base_q     <= base_d;
				count_q    <= count_d;
				rev_q      <= rev_d;
				status_q   <= status_d;
				op_q       <= rls_pkg::op_t'(req.op);
				scan_idx_q <= CW'(1);
				ord_q      <= 1'b1;
			end else begin
				if (state_q == rls_pkg::S_SCAN) begin
					scan_idx_q <= scan_idx_q + CW'(1);
				end
				// upper entry greater than the one below breaks the order
				if (cmp_vld_s1 && ($signed(rdata_a) > $signed(rdata_b))) begin
					ord_q <= 1'b0;
				end
			end
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			top_q        <= empty ? '0 : $signed(rdata_a);
			bottom_q     <= empty ? '0 : $signed(rdata_b);
			cnt_out_q    <= rls_pkg::COUNT_OUT_W'(count_q);
			empty_out_q  <= empty;
			ord_out_q    <= (op_q == rls_pkg::OP_CHECK) && ord_q;
			status_out_q <= status_q;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.top_value    = top_q;
	assign rsp.bottom_value = bottom_q;
	assign rsp.entry_count  = cnt_out_q;
	assign rsp.is_empty     = empty_out_q;
	assign rsp.is_ordered   = ord_out_q;
	assign rsp.status       = status_out_q;

endmodule

`default_nettype wire

// ===== rtl/rls_checker.sv =====
// Port-level assertions for the reversible LIFO stack unit, bound to the top level.
`default_nettype none

module rls_checker (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                rsp_valid,
	input wire logic                                rsp_ready,
	input wire logic signed [rls_pkg::DATA_W-1:0]   top_value,
	input wire logic signed [rls_pkg::DATA_W-1:0]   bottom_value,
	input wire logic [rls_pkg::COUNT_OUT_W-1:0]     entry_count,
	input wire logic                                is_empty,
	input wire logic [rls_pkg::STATUS_W-1:0]        status
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(top_value) && $stable(status))
		else $error("result word changed while stalled");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && is_empty |-> (top_value == '0) && (bottom_value == '0))
		else $error("empty stack reports nonzero top or bottom");

	a_underflow_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == rls_pkg::ST_EMPTY) |-> is_empty)
		else $error("underflow status on a nonempty stack");

	a_full_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == rls_pkg::ST_FULL) |-> !is_empty && (entry_count != '0 || !is_empty))
		else $error("dropped push reported on an empty stack");

endmodule

bind reversible_lifo_stack_unit rls_checker u_rls_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.top_value    (rsp.top_value),
	.bottom_value (rsp.bottom_value),
	.entry_count  (rsp.entry_count),
	.is_empty     (rsp.is_empty),
	.status       (rsp.status)
);

`default_nettype wire

// ===== tb/rls_stack_checker.sv =====
// Checker for the reversible LIFO stack unit: predicts each result word and compares.
module rls_stack_checker import rls_pkg::*; #(
	parameter int STACK_DEPTH = 64
) (
	input  logic clk,
	input  logic arst_n,
	rls_op_if    req,
	rls_res_if   rsp,
	output int   fail_count,
	output int   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [DATA_W-1:0] top_value;
		logic signed [DATA_W-1:0] bottom_value;
		logic [COUNT_OUT_W-1:0]   entry_count;
		logic                     is_empty;
		logic                     is_ordered;
		logic [STATUS_W-1:0]      status;
	} stack_view_t;

	logic [DATA_W-1:0] store_words [STACK_DEPTH];
	int unsigned       base_slot;
	int unsigned       held;
	logic              flipped;
	stack_view_t       pending_views [$];
	stack_view_t       want;
	stack_view_t       got;
	int                mismatches;

	assign fail_count = mismatches;

	// Ring slot of the entry at depth pos counted from the bottom.
	function automatic int unsigned slot_at(input int unsigned pos);
		int unsigned p;
		p = flipped ? base_slot + (held - 1 - pos) : base_slot + pos;
		return p % STACK_DEPTH;
	endfunction

	function automatic void drop_top();
		if (flipped)
			base_slot = (base_slot + 1) % STACK_DEPTH;
		held--;
	endfunction

	function automatic stack_view_t apply_stack_op(input logic [OP_W-1:0] code,
			input logic [DATA_W-1:0] word);
		int unsigned n;
		stack_view_t view;
		view = '0;
		view.status = ST_OK;
		case (code)
			OP_PUSH: begin
				if (held >= STACK_DEPTH) begin
					view.status = ST_FULL;
				end else if (flipped) begin
					base_slot = (base_slot + STACK_DEPTH - 1) % STACK_DEPTH;
					store_words[base_slot] = word;
					held++;
				end else begin
					held++;
					store_words[slot_at(held - 1)] = word;
				end
			end
			OP_POP: begin
				if (held == 0)
					view.status = ST_EMPTY;
				else
					drop_top();
			end
			OP_POPN: begin
				// Clamp: negative takes none, too many takes all.
				if (word[DATA_W-1])
					n = 0;
				else
					n = (word > held) ? held : word;
				if (held == 0 && !word[DATA_W-1] && word != '0)
					view.status = ST_EMPTY;
				while (n > 0) begin
					drop_top();
					n--;
				end
			end
			OP_REMOVE: begin
				if (held == 0) begin
					view.status = ST_EMPTY;
				end else begin
					if (!flipped)
						base_slot = (base_slot + 1) % STACK_DEPTH;
					held--;
				end
			end
			OP_REV: flipped = !flipped;
			OP_CHECK: begin
				view.is_ordered = 1'b1;
				for (int unsigned i = 1; i < held; i++)
					if ($signed(store_words[slot_at(i)]) > $signed(store_words[slot_at(i - 1)]))
						view.is_ordered = 1'b0;
			end
			default: ;
		endcase
		if (held != 0) begin
			view.top_value    = store_words[slot_at(held - 1)];
			view.bottom_value = store_words[slot_at(0)];
		end
		view.entry_count = held[COUNT_OUT_W-1:0];
		view.is_empty    = (held == 0);
		return view;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_slot = 0;
			held      = 0;
			flipped   = 1'b0;
			pending_views.delete();
			outstanding <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				got = '{rsp.top_value, rsp.bottom_value, rsp.entry_count, rsp.is_empty,
					rsp.is_ordered, rsp.status};
				if (pending_views.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result word top=%0d bottom=%0d count=%0d",
						$time, got.top_value, got.bottom_value, got.entry_count);
				end else begin
					want = pending_views.pop_front();
					if (got !== want) begin
						mismatches++;
						$display({"%0t: mismatch expected top=%0d bottom=%0d count=%0d empty=%0b ",
							"ordered=%0b status=%0d, actual top=%0d bottom=%0d count=%0d ",
							"empty=%0b ordered=%0b status=%0d"}, $time,
							want.top_value, want.bottom_value, want.entry_count, want.is_empty,
							want.is_ordered, want.status, got.top_value, got.bottom_value,
							got.entry_count, got.is_empty, got.is_ordered, got.status);
					end
				end
			end
			if (req.valid && req.ready)
				pending_views.push_back(apply_stack_op(req.op, req.value));
			outstanding <= pending_views.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
// Testbench top: clock, reset, operation stimulus, result back-pressure and verdict.
module tb;
	import rls_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int                DEPTH       = 64;
	localparam logic [OP_W-1:0]   OP_UNUSED_A = 3'd6;
	localparam logic [OP_W-1:0]   OP_UNUSED_B = 3'd7;
	localparam logic [DATA_W-1:0] WORD_MAX    = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] WORD_MIN    = 32'h8000_0000;
	localparam logic [DATA_W-1:0] WORD_ONES   = 32'hFFFF_FFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count;
	int   outstanding;
	int   tx_idle_pct = 0;
	int   rx_stall_pct = 0;
	int   sent = 0;

	rls_op_if  op_ch ();
	rls_res_if res_ch ();

	reversible_lifo_stack_unit #(.STACK_DEPTH(DEPTH)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (op_ch),
		.rsp    (res_ch)
	);

	rls_stack_checker #(.STACK_DEPTH(DEPTH)) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (op_ch),
		.rsp         (res_ch),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always #6 clk = ~clk;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_ch.ready <= 1'b0;
		else
			res_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
	end

	initial begin
		#10ms;
		$display("tb: FAIL");
		$finish;
	end

	// Offer one word and hold it until the block takes it.
	task automatic send_word(input logic [OP_W-1:0] code, input logic [DATA_W-1:0] word);
		while ($urandom_range(99) < tx_idle_pct) begin
			op_ch.valid <= 1'b0;
			@(posedge clk);
		end
		op_ch.valid <= 1'b1;
		op_ch.op    <= code;
		op_ch.value <= word;
		@(posedge clk);
		while (!op_ch.ready)
			@(posedge clk);
		sent++;
	endtask

	function automatic logic [DATA_W-1:0] rand_word();
		case ($urandom_range(9))
			0: return WORD_MAX;
			1: return WORD_MIN;
			2: return '0;
			3: return WORD_ONES;
			4: return $urandom_range(20) - 10;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] popn_count();
		case ($urandom_range(9))
			0: return $urandom();
			1: return WORD_MIN | $urandom();
			2: return '0;
			3: return WORD_MAX;
			4: return $urandom_range(70, 9);
			default: return $urandom_range(4, 1);
		endcase
	endfunction

	initial begin
		int     r;
		int     k;
		int     phase_end;
		longint level;
		op_ch.valid  <= 1'b0;
		op_ch.op     <= OP_PUSH;
		op_ch.value  <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty-stack corners, unused codes, field extremes, reversal and clamping.
		send_word(OP_POP, '0);
		send_word(OP_REMOVE, WORD_ONES);
		send_word(OP_POPN, 32'd3);
		send_word(OP_POPN, '0);
		send_word(OP_POPN, WORD_MIN);
		send_word(OP_CHECK, '0);
		send_word(OP_REV, '0);
		send_word(OP_REV, '0);
		send_word(OP_UNUSED_A, WORD_MAX);
		send_word(OP_UNUSED_B, WORD_ONES);
		send_word(OP_PUSH, WORD_MAX);
		send_word(OP_PUSH, WORD_MIN);
		send_word(OP_PUSH, '0);
		send_word(OP_PUSH, WORD_ONES);
		send_word(OP_CHECK, '0);
		send_word(OP_REV, '0);
		send_word(OP_CHECK, '0);
		send_word(OP_PUSH, 32'd5);
		send_word(OP_POP, '0);
		send_word(OP_REMOVE, '0);
		send_word(OP_POPN, 32'd2);
		send_word(OP_POPN, WORD_MAX);
		send_word(OP_POP, '0);
		send_word(OP_PUSH, -32'sd3);
		send_word(OP_PUSH, -32'sd3);
		send_word(OP_CHECK, '0);

		for (int phase = 0; phase < 4; phase++) begin
			phase_end = sent + 200;
			while (sent < phase_end) begin
				case (phase)
					1: begin tx_idle_pct = 63; rx_stall_pct = 0;  end
					2: begin tx_idle_pct = 0;  rx_stall_pct = 63; end
					3: begin tx_idle_pct = 10; rx_stall_pct = 10; end
					default: begin tx_idle_pct = 0; rx_stall_pct = 0; end
				endcase
				// Leave some stretches free of gaps and stalls.
				if ($urandom_range(4) == 0) begin
					tx_idle_pct  = 0;
					rx_stall_pct = 0;
				end
				r = $urandom_range(9);
				if (r < 4) begin
					repeat ($urandom_range(30, 8)) begin
						r = $urandom_range(99);
						if (r < 40)      send_word(OP_PUSH, rand_word());
						else if (r < 52) send_word(OP_POP, $urandom());
						else if (r < 62) send_word(OP_POPN, popn_count());
						else if (r < 72) send_word(OP_REMOVE, $urandom());
						else if (r < 82) send_word(OP_REV, $urandom());
						else if (r < 96) send_word(OP_CHECK, $urandom());
						else             send_word(r[0] ? OP_UNUSED_A : OP_UNUSED_B, $urandom());
					end
				end else if (r == 4) begin
					// Run past full from any state.
					repeat ($urandom_range(68, 65))
						send_word(OP_PUSH, rand_word());
					send_word(OP_CHECK, $urandom());
				end else if (r < 7) begin
					// Clear, then build a non-increasing stack, sometimes topped by a larger entry, and check it both ways.
					send_word(OP_POPN, WORD_MAX);
					if ($urandom_range(1))
						send_word(OP_REV, $urandom());
					level = $signed(rand_word());
					k = ($urandom_range(3) == 0) ? $urandom_range(64, 13) : $urandom_range(12, 1);
					repeat (k) begin
						send_word(OP_PUSH, level[DATA_W-1:0]);
						if ($urandom_range(2) != 0)
							level = level - $urandom_range(500);
						if (level < -64'sd2147483648)
							level = -64'sd2147483648;
					end
					if ($urandom_range(3) == 0) begin
						level = level + 1000;
						if (level > 64'sd2147483647)
							level = 64'sd2147483647;
						send_word(OP_PUSH, level[DATA_W-1:0]);
					end
					send_word(OP_CHECK, $urandom());
					send_word(OP_REV, $urandom());
					send_word(OP_CHECK, $urandom());
				end else if (r < 9) begin
					repeat ($urandom_range(20, 5)) begin
						r = $urandom_range(9);
						if (r < 4)      send_word(OP_POP, $urandom());
						else if (r < 7) send_word(OP_REMOVE, $urandom());
						else            send_word(OP_POPN, popn_count());
					end
				end else begin
					// Wrap the ring base both ways.
					repeat ($urandom_range(30, 10)) begin
						r = $urandom_range(99);
						if (r < 30)      send_word(OP_REV, $urandom());
						else if (r < 60) send_word(OP_PUSH, rand_word());
						else if (r < 85) send_word(OP_REMOVE, $urandom());
						else             send_word(OP_POP, $urandom());
					end
				end
			end
			// Hold off until every result word has come back.
			op_ch.valid <= 1'b0;
			do
				@(posedge clk);
			while (outstanding != 0);
		end

		repeat (100) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
